// ===== design/montgomery_almost_mul_256_top_defines.svh =====
// Assertion macros shared by the almost-Montgomery multiplier.
`ifndef MONTGOMERY_ALMOST_MUL_256_TOP_DEFINES_SVH
`define MONTGOMERY_ALMOST_MUL_256_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("almost-Montgomery multiplier check failed");

// Antecedent implies consequent in the following cycle.
`define MAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("almost-Montgomery multiplier check failed");

`endif

// ===== design/mam_pkg.sv =====
// ----------------------------------------------------------------------------
// mam_pkg
// Widths, register indices and shared types of the almost-Montgomery multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mam_pkg;

	localparam int LIMB_W = 64;
	localparam int LIMBS  = 4;
	localparam int WORD_W = LIMB_W * LIMBS;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_MOD0   = 3'd0,
		REG_MOD1   = 3'd1,
		REG_MOD2   = 3'd2,
		REG_MOD3   = 3'd3,
		REG_FACTOR = 3'd4
	} mam_reg_t;

	// Running accumulator with its 257th bit.
	typedef struct packed {
		logic              top;
		logic [WORD_W-1:0] acc;
	} mam_acc_t;

endpackage

// ===== design/montgomery_almost_mul_256_top.sv =====
// ----------------------------------------------------------------------------
// montgomery_almost_mul_256_top
// Fully pipelined 256-bit almost-Montgomery multiplier with an APB register port.
// ----------------------------------------------------------------------------
// The block accepts one word per clock cycle unless a stalled result waits.
// A word passes four CIOS rounds of eight stages each (three two-stage 64-bit
// multiplications and two wide additions per round), then one stage for the
// conditional modulus subtraction that also holds the result word. A stall on
// the output freezes the whole pipeline, so the input is stalled while a result
// waits. Program the modulus and factor only while no word is in flight.
`timescale 1ns / 1ps

`include "montgomery_almost_mul_256_top_defines.svh"

module montgomery_almost_mul_256_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mam_pkg::ADDR_W-1:0]    paddr,
	input  logic [mam_pkg::DATA_W-1:0]    pwdata,
	output logic [mam_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb0,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb1,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb2,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb3,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb0,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb1,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb2,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb3,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mam_pkg::LIMB_W-1:0]    result_limb0,
	output logic [mam_pkg::LIMB_W-1:0]    result_limb1,
	output logic [mam_pkg::LIMB_W-1:0]    result_limb2,
	output logic [mam_pkg::LIMB_W-1:0]    result_limb3
);

	localparam int LW = mam_pkg::LIMB_W;
	localparam int WW = mam_pkg::WORD_W;
	localparam int NL = mam_pkg::LIMBS;

	logic [LW-1:0] mod_q [NL];
	logic [LW-1:0] factor_q;
	logic [WW-1:0] modulus;
	logic [WW-1:0] result_q;
	logic          valid_q;
	logic          pipe_en;
	logic          cfg_write;

	logic              rnd_valid [NL+1];
	logic [WW-1:0]     rnd_x     [NL+1];
	logic [WW-1:0]     rnd_y     [NL+1];
	mam_pkg::mam_acc_t rnd_acc   [NL+1];
	logic [WW-1:0]     last_acc;
	logic              last_top;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign modulus   = {mod_q[3], mod_q[2], mod_q[1], mod_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				mod_q[i] <= '0;
			end
			factor_q <= '0;
		end else if (cfg_write) begin
			unique case (mam_pkg::mam_reg_t'(paddr[5:3]))
				mam_pkg::REG_MOD0:   mod_q[0] <= pwdata;
				mam_pkg::REG_MOD1:   mod_q[1] <= pwdata;
				mam_pkg::REG_MOD2:   mod_q[2] <= pwdata;
				mam_pkg::REG_MOD3:   mod_q[3] <= pwdata;
				mam_pkg::REG_FACTOR: factor_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mam_pkg::mam_reg_t'(paddr[5:3]))
			mam_pkg::REG_MOD0:   prdata = mod_q[0];
			mam_pkg::REG_MOD1:   prdata = mod_q[1];
			mam_pkg::REG_MOD2:   prdata = mod_q[2];
			mam_pkg::REG_MOD3:   prdata = mod_q[3];
			mam_pkg::REG_FACTOR: prdata = factor_q;
			default:             prdata = '0;
		endcase
	end

	// The whole pipeline advances together unless a finished word is held.
	assign pipe_en  = !(valid_q && out_stall);
	assign in_stall = !pipe_en;

	assign rnd_valid[0]   = in_valid;
	assign rnd_x[0]       = {x_limb3, x_limb2, x_limb1, x_limb0};
	assign rnd_y[0]       = {y_limb3, y_limb2, y_limb1, y_limb0};
	assign rnd_acc[0].acc = '0;
	assign rnd_acc[0].top = 1'b0;

	for (genvar r = 0; r < NL; r++) begin : g_round
		mam_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (rnd_valid[r]),
			.x         (rnd_x[r]),
			.y         (rnd_y[r]),
			.y_word    (rnd_y[r][r*LW +: LW]),
			.acc       (rnd_acc[r]),
			.modulus   (modulus),
			.factor    (factor_q),
			.out_valid (rnd_valid[r+1]),
			.x_out     (rnd_x[r+1]),
			.y_out     (rnd_y[r+1]),
			.acc_out   (rnd_acc[r+1])
		);
	end

	assign last_acc = rnd_acc[NL].acc;
	assign last_top = rnd_acc[NL].top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pipe_en) begin
			valid_q <= rnd_valid[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			result_q <= last_top ? (last_acc - modulus) : last_acc;
		end
	end

	assign out_valid    = valid_q;
	assign result_limb0 = result_q[0*LW +: LW];
	assign result_limb1 = result_q[1*LW +: LW];
	assign result_limb2 = result_q[2*LW +: LW];
	assign result_limb3 = result_q[3*LW +: LW];

	`MAM_ASSERT_NEXT(a_freeze_holds, !pipe_en, $stable(valid_q))
	`MAM_ASSERT_NEXT(a_last_round_delivers, pipe_en && rnd_valid[NL], valid_q)
	`MAM_ASSERT_NEXT(a_no_subtract, pipe_en && rnd_valid[NL] && !last_top, result_q == $past(last_acc))

endmodule

// ===== design/mam_mul64.sv =====
// ----------------------------------------------------------------------------
// mam_mul64
// Two-stage 64x64 to 128-bit multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mam_mul64 (
	input  logic                          clk,
	input  logic                          en,
	input  logic [mam_pkg::LIMB_W-1:0]    a,
	input  logic [mam_pkg::LIMB_W-1:0]    b,
	output logic [2*mam_pkg::LIMB_W-1:0]  p
);

	localparam int HW = mam_pkg::LIMB_W / 2;
	localparam int LW = mam_pkg::LIMB_W;

	logic [LW-1:0] p00_s1, p01_s1, p10_s1, p11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a[HW-1:0]  * b[HW-1:0];
			p01_s1 <= a[HW-1:0]  * b[LW-1:HW];
			p10_s1 <= a[LW-1:HW] * b[HW-1:0];
			p11_s1 <= a[LW-1:HW] * b[LW-1:HW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= {{LW{1'b0}}, p00_s1}
				+ ({{LW{1'b0}}, p01_s1} << HW)
				+ ({{LW{1'b0}}, p10_s1} << HW)
				+ {p11_s1, {LW{1'b0}}};
		end
	end

endmodule

// ===== design/mam_round.sv =====
// ----------------------------------------------------------------------------
// mam_round
// One CIOS round in eight stages: add x times one limb of y, form m, add
// m times the modulus and shift right by one limb.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mam_round (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [mam_pkg::WORD_W-1:0]     x,
	input  logic [mam_pkg::WORD_W-1:0]     y,
	input  logic [mam_pkg::LIMB_W-1:0]     y_word,
	input  mam_pkg::mam_acc_t              acc,
	input  logic [mam_pkg::WORD_W-1:0]     modulus,
	input  logic [mam_pkg::LIMB_W-1:0]     factor,
	output logic                           out_valid,
	output logic [mam_pkg::WORD_W-1:0]     x_out,
	output logic [mam_pkg::WORD_W-1:0]     y_out,
	output mam_pkg::mam_acc_t              acc_out
);

	localparam int LW    = mam_pkg::LIMB_W;
	localparam int WW    = mam_pkg::WORD_W;
	localparam int NL    = mam_pkg::LIMBS;
	localparam int SUM_W = WW + LW + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [WW-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [WW-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7;
	mam_pkg::mam_acc_t acc_s1, acc_s2;
	logic [SUM_W-1:0] v_sum_s3, v_sum_s4, v_sum_s5, v_sum_s6, v_sum_s7;
	logic [2*LW-1:0] pxy [NL];
	logic [2*LW-1:0] pm;
	logic [2*LW-1:0] pn [NL];
	logic [SUM_W-1:0] red_sum;

	for (genvar j = 0; j < NL; j++) begin : g_xy
		mam_mul64 u_mul_xy (
			.clk (clk),
			.en  (en),
			.a   (x[j*LW +: LW]),
			.b   (y_word),
			.p   (pxy[j])
		);
	end

	mam_mul64 u_mul_m (
		.clk (clk),
		.en  (en),
		.a   (v_sum_s3[LW-1:0]),
		.b   (factor),
		.p   (pm)
	);

	for (genvar j = 0; j < NL; j++) begin : g_mn
		mam_mul64 u_mul_mn (
			.clk (clk),
			.en  (en),
			.a   (modulus[j*LW +: LW]),
			.b   (pm[LW-1:0]),
			.p   (pn[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid <= v_s7;
		end
	end

	// Only the carries out of bit 319 of this sum and the stage-3 sum set the new
	// top bit; its low limb is zero in a consistent setup and is dropped.
	assign red_sum = {1'b0, v_sum_s7[SUM_W-2:0]}
		+ {{(LW+1){1'b0}}, pn[2], pn[0]}
		+ {1'b0, pn[3], pn[1], {LW{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;  y_s1 <= y;  acc_s1 <= acc;
			x_s2 <= x_s1; y_s2 <= y_s1; acc_s2 <= acc_s1;
			x_s3 <= x_s2; y_s3 <= y_s2;
			v_sum_s3 <= {{LW{1'b0}}, acc_s2.top, acc_s2.acc}
				+ {{(LW+1){1'b0}}, pxy[2], pxy[0]}
				+ {1'b0, pxy[3], pxy[1], {LW{1'b0}}};
			x_s4 <= x_s3; y_s4 <= y_s3; v_sum_s4 <= v_sum_s3;
			x_s5 <= x_s4; y_s5 <= y_s4; v_sum_s5 <= v_sum_s4;
			x_s6 <= x_s5; y_s6 <= y_s5; v_sum_s6 <= v_sum_s5;
			x_s7 <= x_s6; y_s7 <= y_s6; v_sum_s7 <= v_sum_s6;
			x_out <= x_s7;
			y_out <= y_s7;
			acc_out.acc <= red_sum[SUM_W-2:LW];
			acc_out.top <= v_sum_s7[SUM_W-1] | red_sum[SUM_W-1];
		end
	end

endmodule

// ===== tb/montgomery_almost_mul_256_checker.sv =====
// ----------------------------------------------------------------------------
// montgomery_almost_mul_256_checker
// Watches both channels of the almost-Montgomery multiplier and checks results.
// ----------------------------------------------------------------------------
// Every accepted input word is turned into its expected product by a local
// word-serial CIOS computation, using a copy of the modulus and factor taken
// from the register port. Accepted output words are compared limb by limb.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module montgomery_almost_mul_256_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [mam_pkg::ADDR_W-1:0]    paddr,
	input  logic [mam_pkg::DATA_W-1:0]    pwdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb0,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb1,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb2,
	input  logic [mam_pkg::LIMB_W-1:0]    x_limb3,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb0,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb1,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb2,
	input  logic [mam_pkg::LIMB_W-1:0]    y_limb3,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [mam_pkg::LIMB_W-1:0]    result_limb0,
	input  logic [mam_pkg::LIMB_W-1:0]    result_limb1,
	input  logic [mam_pkg::LIMB_W-1:0]    result_limb2,
	input  logic [mam_pkg::LIMB_W-1:0]    result_limb3,
	output int                            pending,
	output int                            errors
);

	localparam int LIMB_W = mam_pkg::LIMB_W;
	localparam int LIMBS  = mam_pkg::LIMBS;
	localparam int WORD_W = mam_pkg::WORD_W;

	logic [LIMB_W-1:0] modulus [LIMBS];
	logic [LIMB_W-1:0] factor;
	logic [WORD_W-1:0] products [$];

	function automatic logic [WORD_W-1:0] almost_mont_product(
		input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y);
		logic [WORD_W:0]     acc;
		logic [WORD_W+64:0]  wide;
		logic [LIMB_W-1:0]   m;
		logic [WORD_W-1:0]   n;
		n = {modulus[3], modulus[2], modulus[1], modulus[0]};
		acc = '0;
		for (int i = 0; i < LIMBS; i++) begin
			wide = acc + x * y[i*LIMB_W +: LIMB_W];
			m = wide[LIMB_W-1:0] * factor;
			wide = wide + n * m;
			// The low limb of the sum is dropped whatever its value.
			acc = wide[WORD_W+64:LIMB_W];
		end
		if (acc[WORD_W])
			return acc[WORD_W-1:0] - n;
		return acc[WORD_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIMBS; i++)
				modulus[i] <= '0;
			factor <= '0;
			errors <= 0;
			pending <= 0;
			products.delete();
		end else begin
			int bad;
			bad = 0;
			if (psel && penable && pwrite && pready) begin
				if (paddr[5:3] < mam_pkg::REG_FACTOR)
					modulus[paddr[4:3]] <= pwdata;
				else if (paddr[5:3] == mam_pkg::REG_FACTOR)
					factor <= pwdata;
			end
			if (in_valid && !in_stall)
				products.push_back(almost_mont_product(
					{x_limb3, x_limb2, x_limb1, x_limb0},
					{y_limb3, y_limb2, y_limb1, y_limb0}));
			if (out_valid && !out_stall) begin
				if (products.size() == 0) begin
					$display("%0t: unexpected result word %h_%h_%h_%h", $time,
						result_limb3, result_limb2, result_limb1, result_limb0);
					bad = bad + 1;
				end else begin
					logic [WORD_W-1:0] want;
					logic [LIMB_W-1:0] got [LIMBS];
					want = products.pop_front();
					got = '{result_limb0, result_limb1, result_limb2, result_limb3};
					for (int i = 0; i < LIMBS; i++)
						if (got[i] !== want[i*LIMB_W +: LIMB_W]) begin
							$display("%0t: result_limb%0d expected %h actual %h", $time,
								i, want[i*LIMB_W +: LIMB_W], got[i]);
							bad = bad + 1;
						end
				end
			end
			errors <= errors + bad;
			pending <= products.size();
		end
	end

endmodule

// ===== tb/montgomery_almost_mul_256_top_tb.sv =====
// ----------------------------------------------------------------------------
// montgomery_almost_mul_256_top_tb
// Stimulus and verdict for the almost-Montgomery multiplier.
// ----------------------------------------------------------------------------
// Several modulus settings are programmed in turn, including all zeros, all
// ones and an even modulus with an unrelated factor. Each phase sends directed
// extremes and random operands with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module montgomery_almost_mul_256_top_tb;

	localparam int WATCHDOG = 2000;
	localparam int LIMB_W   = mam_pkg::LIMB_W;
	localparam int LIMBS    = mam_pkg::LIMBS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [mam_pkg::ADDR_W-1:0] paddr = '0;
	logic [mam_pkg::DATA_W-1:0] pwdata = '0;
	logic [mam_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [LIMB_W-1:0] x_limb [LIMBS] = '{default: '0};
	logic [LIMB_W-1:0] y_limb [LIMBS] = '{default: '0};
	logic out_valid, out_stall = 1'b0;
	logic [LIMB_W-1:0] result_limb [LIMBS];
	int pending, errors;
	int idle_cycles = 0;
	logic sending_done = 1'b0;

	always #4 clk = ~clk;

	montgomery_almost_mul_256_top dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall,
		.x_limb0(x_limb[0]), .x_limb1(x_limb[1]), .x_limb2(x_limb[2]), .x_limb3(x_limb[3]),
		.y_limb0(y_limb[0]), .y_limb1(y_limb[1]), .y_limb2(y_limb[2]), .y_limb3(y_limb[3]),
		.out_valid, .out_stall,
		.result_limb0(result_limb[0]), .result_limb1(result_limb[1]),
		.result_limb2(result_limb[2]), .result_limb3(result_limb[3])
	);

	montgomery_almost_mul_256_checker checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall,
		.x_limb0(x_limb[0]), .x_limb1(x_limb[1]), .x_limb2(x_limb[2]), .x_limb3(x_limb[3]),
		.y_limb0(y_limb[0]), .y_limb1(y_limb[1]), .y_limb2(y_limb[2]), .y_limb3(y_limb[3]),
		.out_valid, .out_stall,
		.result_limb0(result_limb[0]), .result_limb1(result_limb[1]),
		.result_limb2(result_limb[2]), .result_limb3(result_limb[3]),
		.pending, .errors
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Limbs biased towards the extremes now and then.
	function automatic logic [63:0] operand_limb();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h1 << $urandom_range(0, 63);
			default: return rand64();
		endcase
	endfunction

	// Negated inverse of an odd value modulo 2^64, by Newton iteration.
	function automatic logic [63:0] neg_inverse(input logic [63:0] n);
		logic [63:0] inv;
		inv = n;
		for (int i = 0; i < 6; i++)
			inv = inv * (64'd2 - n * inv);
		return -inv;
	endfunction

	task automatic write_reg(input mam_pkg::mam_reg_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_modulus(input logic [255:0] n, input logic [63:0] f);
		write_reg(mam_pkg::REG_MOD0, n[63:0]);
		write_reg(mam_pkg::REG_MOD1, n[127:64]);
		write_reg(mam_pkg::REG_MOD2, n[191:128]);
		write_reg(mam_pkg::REG_MOD3, n[255:192]);
		write_reg(mam_pkg::REG_FACTOR, f);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The valid line is left high after a word so that words can follow
	// back to back; a gap or a pause takes it down.
	task automatic send_word(input logic [255:0] x, input logic [255:0] y);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		for (int i = 0; i < LIMBS; i++) begin
			x_limb[i] <= x[i*64 +: 64];
			y_limb[i] <= y[i*64 +: 64];
		end
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input logic [255:0] n, input logic [63:0] f, input int count);
		logic [255:0] x, y;
		program_modulus(n, f);
		send_word('0, '0);
		send_word('1, '1);
		send_word(n, '1);
		send_word('1, n);
		send_word(n - 256'd1, n - 256'd1);
		send_word({4{64'h8000_0000_0000_0000}}, {4{64'h0000_0000_0000_0001}});
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < LIMBS; i++) begin
				x[i*64 +: 64] = operand_limb();
				y[i*64 +: 64] = operand_limb();
			end
			send_word(x, y);
			// Let the pipeline empty completely once, halfway through the phase.
			if (k == count / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		drain();
	endtask

	// Receiver stalls: random stretches, with quiet stretches between.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, 14);
			if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b0;
				repeat (n * 4 + 1) @(posedge clk);
			end else begin
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !sending_done) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [255:0] n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		n = {4{64'hFFFF_FFFF_FFFF_FFFF}};
		run_phase(n, neg_inverse(n[63:0]), 300);
		n = {rand64(), rand64(), rand64(), rand64() | 64'h1};
		run_phase(n, neg_inverse(n[63:0]), 800);
		n = {64'h0, 64'h0, 64'h0, 64'h1};
		run_phase(n, neg_inverse(n[63:0]), 200);
		n = {rand64() | 64'h8000_0000_0000_0000, rand64(), rand64(), rand64() | 64'h1};
		run_phase(n, neg_inverse(n[63:0]), 400);
		// Even modulus with an unrelated factor: no modular meaning, still defined.
		n = {rand64(), rand64(), rand64(), rand64() & ~64'h1};
		run_phase(n, rand64(), 200);
		run_phase('0, '0, 60);
		sending_done <= 1'b1;
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
